>>> rtl/core/upsc_pkg.sv
package upsc_pkg;

  localparam int unsigned MAX_WIDTH = 4096;
  localparam int unsigned MAX_SCALE = 99;

  // Field widths fixed by the register map
  localparam int unsigned SCL_W = 7;
  localparam int unsigned COL_W = 13;
  localparam int unsigned PIX_W = 24;

  localparam int unsigned ADDR_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

  localparam int unsigned W_CAP_INT = (MAX_WIDTH > 8191) ? 8191 : MAX_WIDTH;
  localparam int unsigned S_CAP_INT = (MAX_SCALE > 127) ? 127 : MAX_SCALE;
  localparam logic [COL_W-1:0] W_CAP = COL_W'(W_CAP_INT);
  localparam logic [SCL_W-1:0] S_CAP = SCL_W'(S_CAP_INT);

  localparam logic [SCL_W-1:0] SCALE_RST = SCL_W'(1);
  localparam logic [COL_W-1:0] WIDTH_RST = COL_W'(1);

  typedef enum logic {
    CFG_SCALE     = 1'b0,
    CFG_ROW_WIDTH = 1'b1
  } cfg_idx_e;

  typedef enum logic {
    CMD_PUSH = 1'b0,
    CMD_TICK = 1'b1
  } cmd_e;

  // Control fields that travel with a request through the read stage
  typedef struct packed {
    logic       pix;
    logic       rej;
    logic [1:0] pad;
    logic       row_last;
    logic       done;
  } ctl_t;

  function automatic logic [ADDR_W-1:0] clamp_addr(logic [COL_W-1:0] col);
    logic [ADDR_W-1:0] a;
    if (32'(col) >= MAX_WIDTH) begin
      a = ADDR_W'(MAX_WIDTH - 1);
    end else begin
      a = ADDR_W'(col);
    end
    return a;
  endfunction

endpackage

>>> rtl/core/upsc_if.sv
interface upsc_in_if;
  logic       valid;
  logic       ready;
  logic       command;
  logic [7:0] in_blue;
  logic [7:0] in_green;
  logic [7:0] in_red;

  modport source (output valid, command, in_blue, in_green, in_red, input ready);
  modport sink   (input valid, command, in_blue, in_green, in_red, output ready);
endinterface

interface upsc_out_if;
  logic       valid;
  logic       ready;
  logic       out_valid;
  logic       rejected;
  logic [7:0] out_blue;
  logic [7:0] out_green;
  logic [7:0] out_red;
  logic [1:0] pad_bytes;
  logic       row_last;
  logic       source_row_done;

  modport source (output valid, out_valid, rejected, out_blue, out_green, out_red,
                  pad_bytes, row_last, source_row_done, input ready);
  modport sink   (input valid, out_valid, rejected, out_blue, out_green, out_red,
                  pad_bytes, row_last, source_row_done, output ready);
endinterface

>>> rtl/core/pixel_replication_upscaler.sv
// Nearest-neighbor integer upscaler for 24-bit pixel rows.
// req_i carries requests: command 0 pushes a source pixel into the line
// buffer, command 1 asks for one output pixel. Every request yields exactly
// one result on res_o. After row_width pushes the block replays the row:
// each tick returns the next pixel, every source pixel repeated scale times
// and the whole row scale times. row_last marks the end of an output row and
// carries pad_bytes for a 4-byte aligned scanline; source_row_done marks the
// end of the final replay, after which pushes are taken again. A push during
// replay returns rejected; scale 0 drops the filled row.
// Configuration: cfg_we_i writes cfg_data_i to register cfg_idx_i (0 scale,
// 1 row_width) and takes effect at once; write only while idle.
// The line-buffer read lands at the accepting edge; the output register takes the
// result from the read stage once res_o is free, and res_o then shows it.
// Throughput: one request per cycle unless res_o stalls; the RAM has a single port.
// Reset clears counters, returns to the filling phase and sets scale and
// row_width to 1; the line buffer is not cleared. When res_o stalls, the
// read stage and output register hold two results, then req_i.ready drops.
module pixel_replication_upscaler (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic                          cfg_idx_i,
  input  logic [upsc_pkg::COL_W-1:0]    cfg_data_i,
  upsc_in_if.sink                       req_i,
  upsc_out_if.source                    res_o
);

  logic [upsc_pkg::SCL_W-1:0] scale_q, scale_d;
  logic [upsc_pkg::COL_W-1:0] row_width_q, row_width_d;
  logic [upsc_pkg::COL_W-1:0] fill_col_q, fill_col_d;
  logic [upsc_pkg::COL_W-1:0] rd_col_q, rd_col_d;
  logic [upsc_pkg::SCL_W-1:0] h_rep_q, h_rep_d;
  logic [upsc_pkg::SCL_W-1:0] v_rep_q, v_rep_d;
  logic                       replaying_q, replaying_d;

  logic [upsc_pkg::SCL_W-1:0] s_eff;
  logic [upsc_pkg::COL_W-1:0] w_eff;
  logic [3:0]                 ws_low;
  logic [1:0]                 pad_val;

  logic                       acc, is_push;
  logic [upsc_pkg::COL_W-1:0] fill_inc, col_inc;
  logic [upsc_pkg::SCL_W:0]   h_inc, v_inc;
  logic                       fill_end, h_end, col_end, v_end;

  logic                        ram_en, ram_we;
  logic [upsc_pkg::ADDR_W-1:0] ram_addr;
  logic [upsc_pkg::PIX_W-1:0]  ram_wdata, ram_rdata;

  upsc_pkg::ctl_t s1_ctl_q, s1_ctl_d;
  logic           s1_v_q, s1_v_d;
  logic           out_v_q, out_v_d, out_adv;
  upsc_pkg::ctl_t out_ctl_q;
  logic [upsc_pkg::PIX_W-1:0] out_pix_q, s1_pix;

  // Effective register values
  always_comb begin
    s_eff = (scale_q > upsc_pkg::S_CAP) ? upsc_pkg::S_CAP : scale_q;
    if (row_width_q == '0) begin
      w_eff = upsc_pkg::COL_W'(1);
    end else if (row_width_q > upsc_pkg::W_CAP) begin
      w_eff = upsc_pkg::W_CAP;
    end else begin
      w_eff = row_width_q;
    end
    // output scanline bytes mod 4 only depend on the low bits
    ws_low  = 4'(w_eff[1:0] * s_eff[1:0]);
    pad_val = 2'(2'd0 - 2'(ws_low * 4'd3));
  end

  assign out_adv     = !out_v_q || res_o.ready;
  assign req_i.ready = !s1_v_q || out_adv;
  assign acc         = req_i.valid && req_i.ready;
  assign is_push     = (req_i.command == upsc_pkg::CMD_PUSH);

  always_comb begin
    fill_inc = fill_col_q + upsc_pkg::COL_W'(1);
    fill_end = fill_inc >= w_eff;
    h_inc    = {1'b0, h_rep_q} + (upsc_pkg::SCL_W+1)'(1);
    h_end    = h_inc >= {1'b0, s_eff};
    col_inc  = rd_col_q + upsc_pkg::COL_W'(1);
    col_end  = h_end && (col_inc >= w_eff);
    v_inc    = {1'b0, v_rep_q} + (upsc_pkg::SCL_W+1)'(1);
    v_end    = col_end && (v_inc >= {1'b0, s_eff});
  end

  always_comb begin
    scale_d     = scale_q;
    row_width_d = row_width_q;
    fill_col_d  = fill_col_q;
    rd_col_d    = rd_col_q;
    h_rep_d     = h_rep_q;
    v_rep_d     = v_rep_q;
    replaying_d = replaying_q;
    ram_en      = 1'b0;
    ram_we      = 1'b0;
    ram_addr    = upsc_pkg::clamp_addr(rd_col_q);
    ram_wdata   = {req_i.in_red, req_i.in_green, req_i.in_blue};
    s1_ctl_d    = '0;

    if (cfg_we_i) begin
      case (cfg_idx_i)
        upsc_pkg::CFG_SCALE:     scale_d = cfg_data_i[upsc_pkg::SCL_W-1:0];
        upsc_pkg::CFG_ROW_WIDTH: row_width_d = cfg_data_i;
        default: ;
      endcase
    end

    if (acc) begin
      if (!replaying_q) begin
        if (is_push) begin
          ram_en     = 1'b1;
          ram_we     = 1'b1;
          ram_addr   = upsc_pkg::clamp_addr(fill_col_q);
          fill_col_d = fill_end ? '0 : fill_inc;
          if (fill_end && (s_eff != '0)) begin
            replaying_d = 1'b1;
            rd_col_d    = '0;
            h_rep_d     = '0;
            v_rep_d     = '0;
          end
        end
      end else if (is_push) begin
        s1_ctl_d.rej = 1'b1;
      end else begin
        ram_en            = 1'b1;
        s1_ctl_d.pix      = 1'b1;
        s1_ctl_d.row_last = col_end;
        s1_ctl_d.pad      = col_end ? pad_val : 2'd0;
        s1_ctl_d.done     = v_end;
        h_rep_d           = h_end ? '0 : h_inc[upsc_pkg::SCL_W-1:0];
        if (h_end) begin
          rd_col_d = col_end ? '0 : col_inc;
        end
        if (col_end) begin
          v_rep_d = v_end ? '0 : v_inc[upsc_pkg::SCL_W-1:0];
        end
        if (v_end) begin
          replaying_d = 1'b0;
          fill_col_d  = '0;
        end
      end
    end
  end

  // Read data holds while the read stage is stalled: no new request, no new read
  upsc_ram #(
    .WIDTH (upsc_pkg::PIX_W),
    .DEPTH (upsc_pkg::MAX_WIDTH)
  ) u_line_ram (
    .clk_i   (clk_i),
    .en_i    (ram_en),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  assign s1_v_d  = acc ? 1'b1 : (out_adv ? 1'b0 : s1_v_q);
  assign out_v_d = out_adv ? s1_v_q : out_v_q;
  assign s1_pix  = s1_ctl_q.pix ? ram_rdata : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_q     <= upsc_pkg::SCALE_RST;
      row_width_q <= upsc_pkg::WIDTH_RST;
      fill_col_q  <= '0;
      rd_col_q    <= '0;
      h_rep_q     <= '0;
      v_rep_q     <= '0;
      replaying_q <= 1'b0;
      s1_v_q      <= 1'b0;
      out_v_q     <= 1'b0;
    end else begin
      scale_q     <= scale_d;
      row_width_q <= row_width_d;
      fill_col_q  <= fill_col_d;
      rd_col_q    <= rd_col_d;
      h_rep_q     <= h_rep_d;
      v_rep_q     <= v_rep_d;
      replaying_q <= replaying_d;
      s1_v_q      <= s1_v_d;
      out_v_q     <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      s1_ctl_q <= s1_ctl_d;
    end
    if (out_adv && s1_v_q) begin
      out_ctl_q <= s1_ctl_q;
      out_pix_q <= s1_pix;
    end
  end

  assign res_o.valid           = out_v_q;
  assign res_o.out_valid       = out_ctl_q.pix;
  assign res_o.rejected        = out_ctl_q.rej;
  assign res_o.out_blue        = out_pix_q[7:0];
  assign res_o.out_green       = out_pix_q[15:8];
  assign res_o.out_red         = out_pix_q[23:16];
  assign res_o.pad_bytes       = out_ctl_q.pad;
  assign res_o.row_last        = out_ctl_q.row_last;
  assign res_o.source_row_done = out_ctl_q.done;

  // Replay counters sit at zero whenever the block is filling
  a_idle_counters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !replaying_q |-> (rd_col_q == '0 && h_rep_q == '0 && v_rep_q == '0))
    else $error("replay counters not cleared while filling");

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_col_q < upsc_pkg::W_CAP)
    else $error("fill column out of range");

  a_done_ends_replay: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc && replaying_q && !is_push && v_end) |=> !replaying_q)
    else $error("replay did not end after final row");

  a_done_is_row_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_v_q && out_ctl_q.done) |-> (out_ctl_q.row_last && out_ctl_q.pix))
    else $error("source row done without row end");

  a_blank_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_v_q && !out_ctl_q.pix) |-> (out_pix_q == '0 && out_ctl_q.pad == 2'd0
                                     && !out_ctl_q.row_last))
    else $error("non-pixel result carries pixel fields");

endmodule

>>> rtl/core/upsc_ram.sv
module upsc_ram #(
  parameter int unsigned WIDTH = 24,
  parameter int unsigned DEPTH = 4096
) (
  input  logic                                   clk_i,
  input  logic                                   en_i,
  input  logic                                   we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr_i,
  input  logic [WIDTH-1:0]                       wdata_i,
  output logic [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem_q[addr_i] <= wdata_i;
      end else begin
        rdata_q <= mem_q[addr_i];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> dv/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic       out_valid;
    logic       rejected;
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
    logic [1:0] pad;
    logic       row_last;
    logic       done;
  } px_result_t;

  typedef enum logic [1:0] {
    ROW_REQ,
    ROW_SCALE,
    ROW_WIDTH
  } row_kind_e;

  typedef struct packed {
    row_kind_e        kind;
    logic [12:0]      data;
    upsc_pkg::cmd_e   cmd;
    logic [23:0]      px;
    logic             lit;
    px_result_t       want;
  } stim_row_t;

  localparam px_result_t NONE_R = '0;
  localparam px_result_t REJ_R  =
    px_result_t'{1'b0, 1'b1, 8'h00, 8'h00, 8'h00, 2'd0, 1'b0, 1'b0};
  localparam px_result_t BLK_R  =
    px_result_t'{1'b1, 1'b0, 8'h00, 8'h00, 8'h00, 2'd1, 1'b1, 1'b1};
  localparam px_result_t WHT_R  =
    px_result_t'{1'b1, 1'b0, 8'hFF, 8'hFF, 8'hFF, 2'd1, 1'b1, 1'b1};

  localparam int NUM_DIR   = 26;
  localparam int RAND_REQS = 900;

  // literal expectations only where obvious; the rest come from the predictor
  stim_row_t dir_tab [NUM_DIR] = '{
    '{ROW_REQ,   13'd0, upsc_pkg::CMD_TICK, 24'h000000, 1'b1, NONE_R},  // tick while filling
    '{ROW_REQ,   13'd0, upsc_pkg::CMD_PUSH, 24'h000000, 1'b1, NONE_R},
    '{ROW_REQ,   13'd0, upsc_pkg::CMD_PUSH, 24'hFFFFFF, 1'b1, REJ_R},   // push during replay
    '{ROW_REQ,   13'd0, upsc_pkg::CMD_TICK, 24'h000000, 1'b1, BLK_R},
    '{ROW_REQ,   13'd0, upsc_pkg::CMD_PUSH, 24'hFFFFFF, 1'b1, NONE_R},
    '{ROW_REQ,   13'd0, upsc_pkg::CMD_TICK, 24'h000000, 1'b1, WHT_R},
    '{ROW_SCALE, 13'd0, upsc_pkg::CMD_PUSH, 24'h000000, 1'b0, NONE_R},
    '{ROW_REQ,   13'd0, upsc_pkg::CMD_PUSH, 24'h563412, 1'b1, NONE_R},  // row dropped at scale 0
    '{ROW_REQ,   13'd0, upsc_pkg::CMD_TICK, 24'h000000, 1'b1, NONE_R},
    '{ROW_SCALE, 13'd2, upsc_pkg::CMD_PUSH, 24'h000000, 1'b0, NONE_R},
    '{ROW_WIDTH, 13'd0, upsc_pkg::CMD_PUSH, 24'h000000, 1'b0, NONE_R},  // width 0 acts as 1
    '{ROW_REQ,   13'd0, upsc_pkg::CMD_PUSH, 24'hC35AA5, 1'b0, NONE_R},
    '{ROW_REQ,   13'd0, upsc_pkg::CMD_TICK, 24'h000000, 1'b0, NONE_R},
    '{ROW_REQ,   13'd0, upsc_pkg::CMD_TICK, 24'h000000, 1'b0, NONE_R},
    '{ROW_REQ,   13'd0, upsc_pkg::CMD_TICK, 24'h000000, 1'b0, NONE_R},
    '{ROW_REQ,   13'd0, upsc_pkg::CMD_TICK, 24'h000000, 1'b0, NONE_R},
    '{ROW_WIDTH, 13'd2, upsc_pkg::CMD_PUSH, 24'h000000, 1'b0, NONE_R},
    '{ROW_REQ,   13'd0, upsc_pkg::CMD_PUSH, 24'h0F1E2D, 1'b0, NONE_R},
    '{ROW_REQ,   13'd0, upsc_pkg::CMD_PUSH, 24'hF0E1D2, 1'b0, NONE_R},
    '{ROW_REQ,   13'd0, upsc_pkg::CMD_TICK, 24'h000000, 1'b0, NONE_R},
    '{ROW_REQ,   13'd0, upsc_pkg::CMD_PUSH, 24'hAAAAAA, 1'b1, REJ_R},
    '{ROW_REQ,   13'd0, upsc_pkg::CMD_TICK, 24'h000000, 1'b0, NONE_R},
    '{ROW_SCALE, 13'd0, upsc_pkg::CMD_PUSH, 24'h000000, 1'b0, NONE_R},  // scale 0 mid replay
    '{ROW_REQ,   13'd0, upsc_pkg::CMD_TICK, 24'h000000, 1'b0, NONE_R},
    '{ROW_REQ,   13'd0, upsc_pkg::CMD_TICK, 24'h000000, 1'b1, NONE_R},
    '{ROW_SCALE, 13'd1, upsc_pkg::CMD_PUSH, 24'h000000, 1'b0, NONE_R}
  };

  logic                       clk_i;
  logic                       rst_ni;
  logic                       cfg_we;
  logic                       cfg_idx;
  logic [upsc_pkg::COL_W-1:0] cfg_data;

  upsc_in_if  req_if ();
  upsc_out_if res_if ();

  pixel_replication_upscaler u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .req_i      (req_if),
    .res_o      (res_if)
  );

  // predictor state
  logic [23:0]  line_mem [upsc_pkg::MAX_WIDTH];
  int unsigned  fill_col;
  int unsigned  rd_col;
  int unsigned  h_rep;
  int unsigned  v_rep;
  bit           in_replay;
  logic [6:0]   scale_reg;
  logic [12:0]  width_reg;

  px_result_t   pixel_q [$];
  px_result_t   head;
  int           errors;
  int           src_idle_pct;
  int           sink_idle_pct;
  int           sent_cnt;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic int unsigned eff_width(logic [12:0] w);
    if (w == 0) return 1;
    return (32'(w) > upsc_pkg::MAX_WIDTH) ? upsc_pkg::MAX_WIDTH : 32'(w);
  endfunction

  function automatic logic [upsc_pkg::ADDR_W-1:0] line_index(int unsigned col);
    return (col < upsc_pkg::MAX_WIDTH) ? upsc_pkg::ADDR_W'(col)
                                       : upsc_pkg::ADDR_W'(upsc_pkg::MAX_WIDTH - 1);
  endfunction

  function automatic px_result_t upscale_step(upsc_pkg::cmd_e cmd, logic [23:0] px_in);
    px_result_t  r;
    int unsigned w;
    int unsigned s;
    logic [23:0] px;
    r = '0;
    w = eff_width(width_reg);
    s = (32'(scale_reg) > upsc_pkg::MAX_SCALE) ? upsc_pkg::MAX_SCALE : 32'(scale_reg);
    if (!in_replay) begin
      if (cmd == upsc_pkg::CMD_PUSH) begin
        line_mem[line_index(fill_col)] = px_in;
        fill_col = (fill_col + 1) & 32'h1FFF;
        if (fill_col >= w) begin
          fill_col = 0;
          if (s != 0) begin
            in_replay = 1'b1;
            rd_col = 0;
            h_rep = 0;
            v_rep = 0;
          end
        end
      end
    end else if (cmd == upsc_pkg::CMD_PUSH) begin
      r.rejected = 1'b1;
    end else begin
      px = line_mem[line_index(rd_col)];
      r.out_valid = 1'b1;
      r.blue = px[7:0];
      r.green = px[15:8];
      r.red = px[23:16];
      h_rep++;
      if (h_rep >= s) begin
        h_rep = 0;
        rd_col++;
        if (rd_col >= w) begin
          rd_col = 0;
          r.pad = 2'((4 - ((w * s * 3) & 3)) & 3);
          r.row_last = 1'b1;
          v_rep++;
          if (v_rep >= s) begin
            v_rep = 0;
            r.done = 1'b1;
            in_replay = 1'b0;
            fill_col = 0;
          end
        end
      end
    end
    return r;
  endfunction

  task automatic send_req(upsc_pkg::cmd_e cmd, logic [23:0] px, logic lit, px_result_t want);
    px_result_t pred;
    while ($urandom_range(99) < src_idle_pct) begin
      req_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_if.valid    <= 1'b1;
    req_if.command  <= cmd;
    req_if.in_blue  <= px[7:0];
    req_if.in_green <= px[15:8];
    req_if.in_red   <= px[23:16];
    do @(posedge clk_i); while (!req_if.ready);
    pred = upscale_step(cmd, px);
    pixel_q.push_back(lit ? want : pred);
    sent_cnt++;
  endtask

  // only with the pipeline drained
  task automatic write_reg(upsc_pkg::cfg_idx_e idx, logic [12:0] data);
    req_if.valid <= 1'b0;
    while (pixel_q.size() != 0) @(posedge clk_i);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    if (idx == upsc_pkg::CFG_SCALE) begin
      scale_reg = data[6:0];
    end else begin
      width_reg = data;
    end
    @(posedge clk_i);
  endtask

  task automatic check_field(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (res_if.valid && res_if.ready) begin
        if (pixel_q.size() == 0) begin
          $error("result with no request outstanding");
          errors++;
        end else begin
          head = pixel_q.pop_front();
          check_field("out_valid", 8'(head.out_valid), 8'(res_if.out_valid));
          check_field("rejected", 8'(head.rejected), 8'(res_if.rejected));
          check_field("out_blue", head.blue, res_if.out_blue);
          check_field("out_green", head.green, res_if.out_green);
          check_field("out_red", head.red, res_if.out_red);
          check_field("pad_bytes", 8'(head.pad), 8'(res_if.pad_bytes));
          check_field("row_last", 8'(head.row_last), 8'(res_if.row_last));
          check_field("source_row_done", 8'(head.done), 8'(res_if.source_row_done));
        end
      end
      res_if.ready <= ($urandom_range(99) >= sink_idle_pct);
    end
  end

  initial begin
    int             phase;
    int             budget;
    int             n;
    bit             noise;
    logic [6:0]     new_scale;
    logic [12:0]    new_width;
    upsc_pkg::cmd_e cmd;

    clk_i           = 1'b0;
    rst_ni          = 1'b0;
    cfg_we          = 1'b0;
    cfg_idx         = upsc_pkg::CFG_SCALE;
    cfg_data        = '0;
    req_if.valid    = 1'b0;
    req_if.command  = upsc_pkg::CMD_PUSH;
    req_if.in_blue  = '0;
    req_if.in_green = '0;
    req_if.in_red   = '0;
    res_if.ready    = 1'b0;
    errors          = 0;
    sent_cnt        = 0;
    src_idle_pct    = 15;
    sink_idle_pct   = 54;
    foreach (line_mem[i]) line_mem[i] = '0;
    fill_col  = 0;
    rd_col    = 0;
    h_rep     = 0;
    v_rep     = 0;
    in_replay = 1'b0;
    scale_reg = upsc_pkg::SCALE_RST;
    width_reg = upsc_pkg::WIDTH_RST;

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_tab[i]) begin
      case (dir_tab[i].kind)
        ROW_SCALE: write_reg(upsc_pkg::CFG_SCALE, dir_tab[i].data);
        ROW_WIDTH: write_reg(upsc_pkg::CFG_ROW_WIDTH, dir_tab[i].data);
        default:   send_req(dir_tab[i].cmd, dir_tab[i].px, dir_tab[i].lit, dir_tab[i].want);
      endcase
    end

    sent_cnt = 0;
    phase = 0;
    while (sent_cnt < RAND_REQS) begin
      if (sent_cnt < RAND_REQS / 3) begin
        src_idle_pct = 15;
        sink_idle_pct = 54;
      end else if (sent_cnt < 2 * RAND_REQS / 3) begin
        src_idle_pct = 54;
        sink_idle_pct = 15;
      end else begin
        src_idle_pct = 0;
        sink_idle_pct = 0;
      end

      if (phase == 2) begin
        // saturated scale, two output rows of a one-pixel row
        new_scale = 7'd127;
        new_width = 13'd1;
        budget = 1 + 2 * upsc_pkg::MAX_SCALE;
      end else if (phase == 9) begin
        // saturated width, fill cut short by the next width write
        new_scale = 7'd1;
        new_width = 13'h1FFF;
        budget = 120;
      end else begin
        new_scale = ($urandom_range(9) == 0) ? 7'd0 : 7'($urandom_range(6, 1));
        new_width = ($urandom_range(7) == 0) ? 13'($urandom_range(40, 13))
                                             : 13'($urandom_range(12, 1));
        budget = $urandom_range(80, 20);
      end

      // new scale applies mid row, so a pending replay finishes quickly
      write_reg(upsc_pkg::CFG_SCALE, 13'(new_scale));
      // a wider row mid replay would read entries never filled
      if (in_replay && eff_width(new_width) > eff_width(width_reg)) begin
        while (in_replay) send_req(upsc_pkg::CMD_TICK, 24'($urandom()), 1'b0, NONE_R);
      end
      write_reg(upsc_pkg::CFG_ROW_WIDTH, new_width);

      n = 0;
      while (n < budget) begin
        noise = ($urandom_range(9) == 0);
        cmd = (in_replay ^ noise) ? upsc_pkg::CMD_TICK : upsc_pkg::CMD_PUSH;
        if (!noise) n++;
        send_req(cmd, 24'($urandom()), 1'b0, NONE_R);
      end
      phase++;
    end

    req_if.valid <= 1'b0;
    while (pixel_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
